// ===== sv/pwca_pkg.sv =====
`default_nettype none

package pwca_pkg;

	localparam int CHANNELS_DEF = 4;
	localparam int CH_FIELD_W   = 2;
	localparam int TIME_W       = 32;
	localparam int TOOTH_W      = 10;

	typedef enum logic [1:0] {
		OP_RISE    = 2'd0,
		OP_FALL    = 2'd1,
		OP_TRIGGER = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [CH_FIELD_W-1:0] channel;
		logic [TIME_W-1:0]     now_us;
		logic [TIME_W-1:0]     revolution;
		logic [TOOTH_W-1:0]    tooth_index;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0] high_width_us;
		logic [TIME_W-1:0] low_width_us;
		logic [TIME_W-1:0] period_us;
		logic [TIME_W-1:0] prev_total_on_us;
		logic [TIME_W-1:0] offset_us;
		logic [TIME_W-1:0] rise_count;
		logic [TIME_W-1:0] fall_count;
		logic [TIME_W-1:0] cycle_duration_us;
	} result_t;

	typedef struct packed {
		logic [TIME_W-1:0] rise_cnt;
		logic [TIME_W-1:0] fall_cnt;
		logic [TIME_W-1:0] last_rise;
		logic [TIME_W-1:0] last_fall;
		logic [TIME_W-1:0] low_w;
		logic [TIME_W-1:0] high_w;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] on_sum;
		logic [TIME_W-1:0] prev_on_sum;
		logic [TIME_W-1:0] seen_rev;
		logic [TIME_W-1:0] offset;
	} chan_t;

endpackage

`default_nettype wire

// ===== sv/pwca_core.sv =====
`default_nettype none

module pwca_core #(
	parameter int CHANNELS = pwca_pkg::CHANNELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              upd,
	input  wire pwca_pkg::item_t   item,
	output pwca_pkg::result_t      res
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

	pwca_pkg::chan_t ch_q [CHANNELS];
	pwca_pkg::chan_t cur;
	pwca_pkg::chan_t nxt;
	logic [pwca_pkg::TIME_W-1:0] cycle_start_q;
	logic [pwca_pkg::TIME_W-1:0] cycle_dur_q;
	logic [pwca_pkg::TIME_W-1:0] start_nxt;
	logic [pwca_pkg::TIME_W-1:0] dur_nxt;
	logic [pwca_pkg::TIME_W-1:0] hi_w;
	logic [pwca_pkg::TIME_W-1:0] sum;
	logic [IDX_W-1:0]            idx;
	logic                        chan_ok;

	assign chan_ok = {3'b000, item.channel} < CH_LIMIT;
	assign idx     = IDX_W'(item.channel);
	assign cur     = chan_ok ? ch_q[idx] : '0;
	assign hi_w    = item.now_us - cur.last_rise;
	assign sum     = cur.on_sum + hi_w;

	always_comb begin
		nxt       = cur;
		start_nxt = cycle_start_q;
		dur_nxt   = cycle_dur_q;
		priority if (chan_ok && item.opcode == pwca_pkg::OP_RISE) begin
			nxt.rise_cnt  = cur.rise_cnt + 32'd1;
			nxt.low_w     = item.now_us - cur.last_fall;
			nxt.period    = item.now_us - cur.last_rise;
			nxt.last_rise = item.now_us;
		end else if (chan_ok && item.opcode == pwca_pkg::OP_FALL) begin
			nxt.fall_cnt  = cur.fall_cnt + 32'd1;
			nxt.high_w    = hi_w;
			nxt.on_sum    = sum;
			nxt.last_fall = item.now_us;
			// new revolution: close out the accumulator
			if (cur.seen_rev != item.revolution) begin
				nxt.seen_rev    = item.revolution;
				nxt.prev_on_sum = sum;
				nxt.on_sum      = '0;
				nxt.offset      = item.now_us - cycle_start_q;
			end
		end else if (item.opcode == pwca_pkg::OP_TRIGGER && item.tooth_index == '0) begin
			dur_nxt   = item.now_us - cycle_start_q;
			start_nxt = item.now_us;
		end else begin
			// unused opcode, later tooth or channel out of range: state holds
		end
	end

	always_comb begin
		res.high_width_us     = nxt.high_w;
		res.low_width_us      = nxt.low_w;
		res.period_us         = nxt.period;
		res.prev_total_on_us  = nxt.prev_on_sum;
		res.offset_us         = nxt.offset;
		res.rise_count        = nxt.rise_cnt;
		res.fall_count        = nxt.fall_cnt;
		res.cycle_duration_us = dur_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				ch_q[i] <= '0;
			end
			cycle_start_q <= '0;
			cycle_dur_q   <= '0;
		end else if (upd) begin
			if (chan_ok) begin
				ch_q[idx] <= nxt;
			end
			cycle_start_q <= start_nxt;
			cycle_dur_q   <= dur_nxt;
		end
	end

	a_rise_time: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && chan_ok && item.opcode == pwca_pkg::OP_RISE)
		|=> ch_q[$past(idx)].last_rise == $past(item.now_us))
		else $error("rise did not record its time");

	a_fall_width: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && chan_ok && item.opcode == pwca_pkg::OP_FALL)
		|=> ch_q[$past(idx)].high_w == $past(item.now_us - cur.last_rise))
		else $error("fall stored a wrong high width");

	a_cycle_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && item.opcode == pwca_pkg::OP_TRIGGER && item.tooth_index == '0)
		|=> cycle_start_q == $past(item.now_us))
		else $error("tooth zero did not restart the cycle");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(cycle_start_q) && $stable(cycle_dur_q))
		else $error("cycle registers moved without a request");

endmodule

`default_nettype wire

// ===== sv/pulse_width_capture_analyzer_unit.sv =====
// channel   dir  signals                         content
// s_axis    in   tvalid tready tdata[79:0] tuser[3:0]  one edge or trigger request
// m_axis    out  tvalid tready tdata[255:0]          channel report after the update
//
// one request per cycle sustained while the output is not stalled; each request passes through the
// input register, then update logic into the result register
// state read-modify-write for the addressed channel reads combinationally and writes on the update,
// so back-to-back requests on the same channel need no forwarding
// asynchronous active-low reset clears all per-channel and cycle state
// a stalled output holds the result while the input register may still take a request
`default_nettype none

module pulse_width_capture_analyzer_unit #(
	parameter int CHANNELS = pwca_pkg::CHANNELS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [31:0] now_us, [63:32] revolution, [73:64] tooth_index, [79:74] zero
	input  wire logic [79:0]  s_axis_tdata,
	// [1:0] opcode, [3:2] channel
	input  wire logic [3:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [31:0] high_width_us, [63:32] low_width_us, [95:64] period_us,
	// [127:96] prev_total_on_us, [159:128] offset_us, [191:160] rise_count,
	// [223:192] fall_count, [255:224] cycle_duration_us
	output logic [255:0]      m_axis_tdata
);

	pwca_pkg::item_t   item_s1;
	pwca_pkg::result_t res;
	pwca_pkg::result_t res_q;
	logic              valid_s1;
	logic              out_valid_q;
	logic              adv;
	logic              take;

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.opcode      <= s_axis_tuser[1:0];
			item_s1.channel     <= s_axis_tuser[3:2];
			item_s1.now_us      <= s_axis_tdata[31:0];
			item_s1.revolution  <= s_axis_tdata[63:32];
			item_s1.tooth_index <= s_axis_tdata[73:64];
		end
		if (adv) begin
			res_q <= res;
		end
	end

	pwca_core #(
		.CHANNELS(CHANNELS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.upd   (adv),
		.item  (item_s1),
		.res   (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_q.cycle_duration_us, res_q.fall_count, res_q.rise_count,
		res_q.offset_us, res_q.prev_total_on_us, res_q.period_us,
		res_q.low_width_us, res_q.high_width_us};

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("empty input register refused a request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or vanished");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s_axis_tready) |=> valid_s1 && $stable(item_s1))
		else $error("waiting request changed or vanished");

endmodule

`default_nettype wire
